// ----- hdl/kaf_pkg.sv -----
// Package for the two-state angle Kalman filter: reset values of the settings,
// register indexes, fixed-point widths and a saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kaf_pkg;

    localparam int STATE_FRAC = 24;
    localparam int STATE_W    = 32;
    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int DEFAULT_FRAC_BITS  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 3'd3;

    localparam logic [31:0] ANGLE_NOISE_RESET = 32'd16777;
    localparam logic [31:0] BIAS_NOISE_RESET  = 32'd50332;
    localparam logic [31:0] MEAS_NOISE_RESET  = 32'd503316;
    localparam logic [23:0] INTERVAL_RESET    = 24'd83886;

    // Multiplier operand and rounded product widths.
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_Q_W = MUL_P_W - STATE_FRAC;

    // Divider: dividend is |p| * 2^24, divisor is |S|.
    localparam int DIV_NUM_W = STATE_W + STATE_FRAC;
    localparam int DIV_DEN_W = 34;

    localparam int SAT_W = 48;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7fff_ffff);
        lo = -hi - SAT_W'(1);
        if (v > hi)
            return 32'sh7fff_ffff;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[STATE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/kaf_div.sv -----
// Bit-serial signed divider for the Kalman gain: q = num * 2^24 / den,
// truncated toward zero and saturated to 32 bits; zero when den is zero.
// Depends on kaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kaf_div (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [kaf_pkg::STATE_W-1:0]     num,
    input  wire logic signed [kaf_pkg::DIV_DEN_W-1:0]   den,
    output logic                                        done,
    output logic signed [kaf_pkg::STATE_W-1:0]          quot
);
    import kaf_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_NUM_W - 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_DEN_W-1:0]  dsr_reg;
    logic [DIV_NUM_W-1:0]  dvd_reg;
    logic [DIV_NUM_W-1:0]  q_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic signed [STATE_W-1:0] quot_reg;

    logic [DIV_DEN_W:0]    trial;
    logic                  ge;
    logic [DIV_DEN_W-1:0]  rem_next;
    logic [DIV_NUM_W-1:0]  q_next;
    logic [STATE_W-1:0]    num_mag;
    logic [DIV_DEN_W-1:0]  den_mag;
    logic signed [STATE_W-1:0] quot_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_NUM_W-1]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = ge ? DIV_DEN_W'(trial - {1'b0, dsr_reg}) : trial[DIV_DEN_W-1:0];
        q_next   = {q_reg[DIV_NUM_W-2:0], ge};
        num_mag  = num[STATE_W-1] ? STATE_W'(-num) : STATE_W'(num);
        den_mag  = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);
        if (!neg_reg)
        begin
            if (q_next[DIV_NUM_W-1:STATE_W-1] != '0)
                quot_next = 32'sh7fff_ffff;
            else
                quot_next = signed'(q_next[STATE_W-1:0]);
        end
        else
        begin
            if (q_next[DIV_NUM_W-1:STATE_W] != '0 ||
                (q_next[STATE_W-1] && q_next[STATE_W-2:0] != '0))
                quot_next = 32'sh8000_0000;
            else
                quot_next = signed'(STATE_W'(-q_next[STATE_W-1:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    quot_reg <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                rem_reg <= '0;
                dsr_reg <= den_mag;
                dvd_reg <= {num_mag, {STATE_FRAC{1'b0}}};
                q_reg   <= '0;
                neg_reg <= num[STATE_W-1] ^ den[DIV_DEN_W-1];
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                dvd_reg <= {dvd_reg[DIV_NUM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= quot_next;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

// ----- hdl/kalman_angle_filter.sv -----
// Top level of the two-state angle Kalman filter: settings registers, sequencer,
// shared multiplier and state. Depends on kaf_pkg and kaf_div.
//
// Usage. One input beat carries measured_angle and measured_rate (signed,
// FRAC_BITS fraction bits). It is taken at a rising edge with in_valid high
// and in_stall low. The block then works on that beat alone and holds
// in_stall high until the result is placed in the output register.
// Each result beat carries filtered_angle and corrected_rate and leaves at an
// edge with out_valid high and out_stall low.
// Work per beat: ten multiply steps on one shared 36x33 multiplier, with the two
// gain divisions between the prediction and update steps, done in a divider that
// retires one quotient bit per cycle, and then the load of the output register.
// A division by a zero innovation variance skips the bit loop and yields a zero
// gain.
// While a finished result waits under out_stall, the next beat is still taken;
// its own result waits until the output register is free.
// Settings are written on the cfg channel (cfg_ready is always high); an
// unknown index is ignored. Settings must only change while idle.
// Reset clears the state estimates and covariance to zero, loads the default
// settings and empties the output register. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module kalman_angle_filter #(
    parameter int DATA_WIDTH = kaf_pkg::DEFAULT_DATA_WIDTH,
    parameter int FRAC_BITS  = kaf_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [DATA_WIDTH-1:0]          measured_angle,
    input  wire logic signed [DATA_WIDTH-1:0]          measured_rate,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [DATA_WIDTH-1:0]               filtered_angle,
    output logic signed [DATA_WIDTH-1:0]               corrected_rate,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [kaf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [kaf_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import kaf_pkg::*;

    // Shift between the port format and the internal Q8.24 format.
    localparam int IO_SHIFT = STATE_FRAC - FRAC_BITS;
    // Wide enough for a port value shifted up into Q8.24.
    localparam int WS = DATA_WIDTH + IO_SHIFT + 1;
    // Rounded state word brought back to port format.
    localparam int RW = STATE_W + 2;
    // Difference of a port value and a rounded state word.
    localparam int EW = ((DATA_WIDTH > RW) ? DATA_WIDTH : RW) + 1;
    localparam logic signed [RW-1:0] HALF =
        (IO_SHIFT > 0) ? (RW'(1) <<< ((IO_SHIFT > 0) ? IO_SHIFT - 1 : 0)) : RW'(0);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_APPLY, S_DIV0, S_DIVW0, S_DIV1, S_DIVW1, S_OUT
    } state_t;

    // Multiply steps, in the order they run.
    typedef enum logic [3:0] {
        ST_RATE, ST_DTP, ST_PAA, ST_PBB, ST_AK0, ST_BK1,
        ST_P00, ST_P01, ST_P10, ST_P11
    } step_t;

    function automatic logic signed [STATE_W-1:0] sat_ws(input logic signed [WS-1:0] v);
        logic signed [WS-1:0] hi;
        hi = WS'(32'sh7fff_ffff);
        if (v > hi)
            return 32'sh7fff_ffff;
        else if (v < -hi - WS'(1))
            return 32'sh8000_0000;
        else
            return v[STATE_W-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] hi;
        hi = (EW'(1) <<< (DATA_WIDTH - 1)) - EW'(1);
        if (v > hi)
            return {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else if (v < -hi - EW'(1))
            return {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            return v[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [STATE_W-1:0] to_state(input logic signed [DATA_WIDTH-1:0] v);
        return sat_ws(WS'(v) <<< IO_SHIFT);
    endfunction

    // Round half up from Q8.24 to port format.
    function automatic logic signed [RW-1:0] to_io(input logic signed [STATE_W-1:0] v);
        return (RW'(v) + HALF) >>> IO_SHIFT;
    endfunction

    // Settings.
    logic [31:0] apn_reg, bpn_reg, mn_reg;
    logic [23:0] dt_reg;

    // Filter state.
    logic signed [STATE_W-1:0] angle_reg, bias_reg, paa_reg, pab_reg, pba_reg, pbb_reg;

    // Per-beat working registers.
    state_t state_reg;
    step_t  step_reg;
    logic signed [DATA_WIDTH-1:0] ma_reg;
    logic signed [STATE_W-1:0]    rate_reg, y_reg, p00_reg, p01_reg, k0_reg, k1_reg;
    logic signed [STATE_W:0]      t2_reg;
    logic signed [DATA_WIDTH-1:0] rate_out_reg;
    logic signed [MUL_Q_W-1:0]    prod_reg;

    logic out_valid_reg;
    logic signed [DATA_WIDTH-1:0] fa_reg, cr_reg;

    // Shared multiplier operands.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_B_W-1:0] dt_s;
    logic signed [MUL_A_W-1:0] inner;

    logic div_start, div_done;
    logic signed [STATE_W-1:0] div_num, div_quot;
    logic signed [DIV_DEN_W-1:0] innov_var;

    logic signed [STATE_W-1:0] rate_in;
    logic signed [DATA_WIDTH-1:0] rate_out_in;
    logic signed [SAT_W-1:0] q_ext;
    logic out_free;

    assign dt_s = signed'(MUL_B_W'(dt_reg));
    assign inner = MUL_A_W'(t2_reg) - MUL_A_W'(pab_reg) - MUL_A_W'(pba_reg)
                 + signed'(MUL_A_W'(apn_reg));
    assign innov_var = DIV_DEN_W'(paa_reg) + signed'(DIV_DEN_W'(mn_reg));
    assign q_ext = SAT_W'(prod_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // The internal rate and the reported rate both use the bias from before the beat.
    assign rate_in = sat32(SAT_W'(to_state(measured_rate)) - SAT_W'(bias_reg));
    assign rate_out_in = sat_dw(EW'(measured_rate) - EW'(to_io(bias_reg)));

    always_comb
    begin
        unique case (step_reg)
            ST_RATE: begin mul_a = MUL_A_W'(rate_reg);          mul_b = dt_s;               end
            ST_DTP:  begin mul_a = MUL_A_W'(pbb_reg);           mul_b = dt_s;               end
            ST_PAA:  begin mul_a = inner;                       mul_b = dt_s;               end
            ST_PBB:  begin mul_a = signed'(MUL_A_W'(bpn_reg));  mul_b = dt_s;               end
            ST_AK0:  begin mul_a = MUL_A_W'(y_reg);             mul_b = MUL_B_W'(k0_reg);   end
            ST_BK1:  begin mul_a = MUL_A_W'(y_reg);             mul_b = MUL_B_W'(k1_reg);   end
            ST_P00:  begin mul_a = MUL_A_W'(p00_reg);           mul_b = MUL_B_W'(k0_reg);   end
            ST_P01:  begin mul_a = MUL_A_W'(p01_reg);           mul_b = MUL_B_W'(k0_reg);   end
            ST_P10:  begin mul_a = MUL_A_W'(p00_reg);           mul_b = MUL_B_W'(k1_reg);   end
            ST_P11:  begin mul_a = MUL_A_W'(p01_reg);           mul_b = MUL_B_W'(k1_reg);   end
            default: begin mul_a = '0;                          mul_b = '0;                 end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign div_start = (state_reg == S_DIV0) || (state_reg == S_DIV1);
    assign div_num   = (state_reg == S_DIV0) ? paa_reg : pba_reg;

    kaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (innov_var),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Settings registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apn_reg <= ANGLE_NOISE_RESET;
            bpn_reg <= BIAS_NOISE_RESET;
            mn_reg  <= MEAS_NOISE_RESET;
            dt_reg  <= INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ANGLE_NOISE: apn_reg <= cfg_data;
                REG_BIAS_NOISE:  bpn_reg <= cfg_data;
                REG_MEAS_NOISE:  mn_reg  <= cfg_data;
                REG_INTERVAL:    dt_reg  <= cfg_data[23:0];
                default:         ;
            endcase
        end
    end

    // Sequencer, filter state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_RATE;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            paa_reg       <= '0;
            pab_reg       <= '0;
            pba_reg       <= '0;
            pbb_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ma_reg       <= measured_angle;
                        rate_reg     <= rate_in;
                        rate_out_reg <= rate_out_in;
                        step_reg     <= ST_RATE;
                        state_reg    <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // Round half up and drop to Q8.24.
                    prod_reg  <= MUL_Q_W'((mul_p + MUL_P_W'(1 << (STATE_FRAC - 1)))
                                          >>> STATE_FRAC);
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg <= S_MUL;
                    step_reg  <= step_t'(step_reg + 4'd1);
                    unique case (step_reg)
                        ST_RATE: angle_reg <= sat32(SAT_W'(angle_reg) + q_ext);
                        ST_DTP:  t2_reg    <= prod_reg[STATE_W:0];
                        ST_PAA:
                        begin
                            paa_reg <= sat32(SAT_W'(paa_reg) + q_ext);
                            pab_reg <= sat32(SAT_W'(pab_reg) - SAT_W'(t2_reg));
                            pba_reg <= sat32(SAT_W'(pba_reg) - SAT_W'(t2_reg));
                        end
                        ST_PBB:
                        begin
                            pbb_reg   <= sat32(SAT_W'(pbb_reg) + q_ext);
                            state_reg <= S_DIV0;
                        end
                        ST_AK0:  angle_reg <= sat32(SAT_W'(angle_reg) + q_ext);
                        ST_BK1:  bias_reg  <= sat32(SAT_W'(bias_reg) + q_ext);
                        ST_P00:  paa_reg   <= sat32(SAT_W'(p00_reg) - q_ext);
                        ST_P01:  pab_reg   <= sat32(SAT_W'(p01_reg) - q_ext);
                        ST_P10:  pba_reg   <= sat32(SAT_W'(pba_reg) - q_ext);
                        ST_P11:
                        begin
                            pbb_reg   <= sat32(SAT_W'(pbb_reg) - q_ext);
                            state_reg <= S_OUT;
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_DIV0:
                begin
                    // Innovation against the predicted angle, and the covariance
                    // words that the shrink step reads after it rewrites them.
                    y_reg     <= sat32(SAT_W'(to_state(ma_reg)) - SAT_W'(angle_reg));
                    p00_reg   <= paa_reg;
                    p01_reg   <= pab_reg;
                    state_reg <= S_DIVW0;
                end
                S_DIVW0:
                begin
                    if (div_done)
                    begin
                        k0_reg    <= div_quot;
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1:
                    state_reg <= S_DIVW1;
                S_DIVW1:
                begin
                    if (div_done)
                    begin
                        k1_reg    <= div_quot;
                        step_reg  <= ST_AK0;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        fa_reg        <= sat_dw(EW'(to_io(angle_reg)));
                        cr_reg        <= rate_out_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign filtered_angle = fa_reg;
    assign corrected_rate = cr_reg;

endmodule
`default_nettype wire

// ----- hdl/kalman_angle_filter_chk.sv -----
// Port-level checker for kalman_angle_filter, bound to the top level.
// Depends on kalman_angle_filter.
`timescale 1ns / 1ps
`default_nettype none
module kalman_angle_filter_chk #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [DATA_WIDTH-1:0] filtered_angle,
    input wire logic [DATA_WIDTH-1:0] corrected_rate,
    input wire logic                  cfg_ready
);
    // An accepted beat keeps the input side busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // The input side is still busy while the first multiply result is applied.
    a_no_quick_reaccept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 in_stall)
        else $error("input taken too soon after an accept");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered_angle)
            && $stable(corrected_rate))
        else $error("stalled result changed");

    // The settings port never pushes back.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("settings port not ready");

endmodule

bind kalman_angle_filter kalman_angle_filter_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_angle (filtered_angle),
    .corrected_rate (corrected_rate),
    .cfg_ready      (cfg_ready)
);
`default_nettype wire

// ----- sim/tb_kalman_angle_filter.sv -----
// Self-checking testbench for kalman_angle_filter: a queue-fed input driver, an output
// monitor with random backpressure and a fixed-point predictor of the filter.
// Depends on kaf_pkg and the filter RTL.
`timescale 1ns / 1ps
module tb_kalman_angle_filter;

    import kaf_pkg::*;

    // Index that matches no register; writes to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

    localparam int  DW        = 32;
    localparam int  WATCHDOG  = 5000;
    localparam int  DRAIN_GAP = 200;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [DW-1:0] angle;
        logic signed [DW-1:0] rate;
    } sensor_beat_t;

    typedef struct {
        logic signed [DW-1:0] angle;
        logic signed [DW-1:0] rate;
    } estimate_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [DW-1:0] measured_angle = '0;
    logic signed [DW-1:0] measured_rate = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [DW-1:0] filtered_angle;
    logic signed [DW-1:0] corrected_rate;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ANGLE_NOISE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kalman_angle_filter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measured_angle (measured_angle),
        .measured_rate  (measured_rate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_angle (filtered_angle),
        .corrected_rate (corrected_rate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    // Beats still to be sent and filter outputs still to arrive.
    sensor_beat_t sensor_queue[$];
    estimate_t    estimate_queue[$];

    int failures = 0;
    int beats_in = 0;
    int beats_out = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;     // while set, neither side inserts gaps or stalls

    // Settings as the predictor sees them, starting from their reset values.
    longint q_angle = longint'(ANGLE_NOISE_RESET);
    longint q_bias  = longint'(BIAS_NOISE_RESET);
    longint r_meas  = longint'(MEAS_NOISE_RESET);
    longint dt      = longint'(INTERVAL_RESET);

    // Filter state in Q8.24, held as 64-bit values that always fit 32 bits.
    longint angle_est = 0;
    longint bias_est  = 0;
    longint p_aa = 0;
    longint p_ab = 0;
    longint p_ba = 0;
    longint p_bb = 0;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_word(input longint v);
        return clamp(v, WORD_MIN, WORD_MAX);
    endfunction

    // Q8.24 product rounded half up.
    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (STATE_FRAC - 1))) >>> STATE_FRAC;
    endfunction

    // Q16.16 input widened to Q8.24 with saturation.
    function automatic longint widen(input longint v);
        return sat_word(clamp(v, -(64'sd1 <<< 40), 64'sd1 <<< 40) * 256);
    endfunction

    // Q8.24 narrowed to Q16.16, rounded half up.
    function automatic longint narrow(input longint v);
        return (v + 64'sd128) >>> 8;
    endfunction

    function automatic longint kalman_gain(input longint p, input longint s);
        if (s == 0)
            return 0;
        return sat_word((p * (64'sd1 <<< STATE_FRAC)) / s);
    endfunction

    // One filter step for an accepted sensor beat; queues the estimate it must yield.
    task automatic track_beat(input sensor_beat_t b);
        longint a_meas;
        longint r_meas_in;
        longint rate;
        longint p11;
        longint s;
        longint k0;
        longint k1;
        longint innov;
        longint p00;
        longint p01;
        estimate_t e;
        a_meas    = longint'(b.angle);
        r_meas_in = longint'(b.rate);
        e.rate    = DW'(sat_word(r_meas_in - narrow(bias_est)));

        rate      = sat_word(widen(r_meas_in) - bias_est);
        angle_est = sat_word(angle_est + fx_mul(dt, rate));
        p11  = p_bb;
        p_aa = sat_word(p_aa + fx_mul(dt, fx_mul(dt, p11) - p_ab - p_ba + q_angle));
        p_ab = sat_word(p_ab - fx_mul(dt, p11));
        p_ba = sat_word(p_ba - fx_mul(dt, p11));
        p_bb = sat_word(p11 + fx_mul(q_bias, dt));

        s  = p_aa + r_meas;
        k0 = kalman_gain(p_aa, s);
        k1 = kalman_gain(p_ba, s);

        innov     = sat_word(widen(a_meas) - angle_est);
        angle_est = sat_word(angle_est + fx_mul(k0, innov));
        bias_est  = sat_word(bias_est + fx_mul(k1, innov));
        p00  = p_aa;
        p01  = p_ab;
        p_aa = sat_word(p00 - fx_mul(k0, p00));
        p_ab = sat_word(p01 - fx_mul(k0, p01));
        p_ba = sat_word(p_ba - fx_mul(k1, p00));
        p_bb = sat_word(p_bb - fx_mul(k1, p01));

        e.angle = DW'(sat_word(narrow(angle_est)));
        estimate_queue.push_back(e);
    endtask

    // Mostly no gap, often a short one, now and then a long one, none at all in steady stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Sensor driver. A stalled beat is held unchanged; after each accepted beat a gap
    // may follow before the next one is presented.
    int send_gap = 0;
    sensor_beat_t next_beat;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_beat('{angle: measured_angle, rate: measured_rate});
                beats_in++;
                send_gap = pick_gap();
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sensor_queue.size() > 0)
                begin
                    next_beat = sensor_queue.pop_front();
                    in_valid <= 1'b1;
                    measured_angle <= next_beat.angle;
                    measured_rate <= next_beat.rate;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each accepted beat is checked against the oldest estimate;
    // out_stall is raised for random stretches, long ones included.
    int stall_left = 0;
    estimate_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (estimate_queue.size() == 0)
                begin
                    $error("unexpected output beat: filtered_angle %0d corrected_rate %0d",
                           filtered_angle, corrected_rate);
                    failures++;
                end
                else
                begin
                    want = estimate_queue.pop_front();
                    if (filtered_angle !== want.angle)
                    begin
                        $error("filtered_angle: expected %0d, got %0d",
                               want.angle, filtered_angle);
                        failures++;
                    end
                    if (corrected_rate !== want.rate)
                    begin
                        $error("corrected_rate: expected %0d, got %0d",
                               want.rate, corrected_rate);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            out_stall <= (stall_left > 0);
        end
    end

    // Watchdog: the run ends once no channel has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Register write over the settings channel; the predictor follows the same write.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE: q_angle = longint'(val);
            REG_BIAS_NOISE:  q_bias  = longint'(val);
            REG_MEAS_NOISE:  r_meas  = longint'(val);
            REG_INTERVAL:    dt      = longint'(val[23:0]);
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] qa, input logic [31:0] qb,
                             input logic [31:0] rm, input logic [31:0] ts);
        write_setting(REG_ANGLE_NOISE, qa);
        write_setting(REG_BIAS_NOISE, qb);
        write_setting(REG_MEAS_NOISE, rm);
        write_setting(REG_INTERVAL, ts);
    endtask

    // Mostly plausible tilt data (within +-90 degrees and +-2000 deg/s), with full-range
    // noise and the word extremes mixed in.
    function automatic sensor_beat_t rand_beat();
        sensor_beat_t b;
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
        begin
            b.angle = $signed($urandom_range(0, 11796480)) - 32'sd5898240;
            b.rate  = $signed($urandom_range(0, 262144000)) - 32'sd131072000;
        end
        else if (roll < 9)
        begin
            b.angle = $urandom;
            b.rate  = $urandom;
        end
        else
        begin
            b.angle = ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
            b.rate  = ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
        end
        return b;
    endfunction

    // The block is idle once every beat is sent and every estimate has come back.
    task automatic drain();
        while (sensor_queue.size() != 0 || in_valid || estimate_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            sensor_queue.push_back(rand_beat());
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats on the reset settings: word extremes and a plain tilt sequence.
        sensor_queue.push_back('{angle: 32'sd0, rate: 32'sd0});
        sensor_queue.push_back('{angle: 32'sh7fff_ffff, rate: 32'sh7fff_ffff});
        sensor_queue.push_back('{angle: 32'sh8000_0000, rate: 32'sh8000_0000});
        sensor_queue.push_back('{angle: 32'sh7fff_ffff, rate: 32'sh8000_0000});
        sensor_queue.push_back('{angle: 32'sh8000_0000, rate: 32'sh7fff_ffff});
        sensor_queue.push_back('{angle: -32'sd1, rate: 32'sd1});
        for (int i = 0; i < 6; i++)
            sensor_queue.push_back('{angle: 32'sd655360, rate: -32'sd65536});
        drain();

        // With zero noise and zero interval the innovation variance is the angle covariance
        // alone; the write to an unknown index must change nothing.
        write_all(32'd0, 32'd0, 32'd0, 32'd0);
        write_setting(REG_UNUSED, 32'hffff_ffff);
        sensor_queue.push_back('{angle: 32'sd0, rate: 32'sd0});
        sensor_queue.push_back('{angle: 32'sd3276800, rate: 32'sd65536});
        sensor_queue.push_back('{angle: 32'sh8000_0000, rate: 32'sh7fff_ffff});
        sensor_queue.push_back('{angle: -32'sd3276800, rate: -32'sd65536});
        drain();

        // Every setting at its maximum; the interval write also carries upper bits
        // that the register must drop.
        steady = 1'b1;
        write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        random_phase(100);
        steady = 1'b0;

        // Smallest measurement noise against a large angle noise and the longest
        // interval drives the covariance into saturation.
        write_all(32'hffff_ffff, 32'd0, 32'd1, 32'h00ff_ffff);
        random_phase(100);

        write_all(ANGLE_NOISE_RESET, BIAS_NOISE_RESET, MEAS_NOISE_RESET,
                  {8'd0, INTERVAL_RESET});
        random_phase(150);

        for (int ph = 0; ph < 3; ph++)
        begin
            write_all($urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0100_0000),
                      $urandom_range(1, 32'h0200_0000), $urandom_range(0, 32'h0020_0000));
            random_phase(80);
        end

        $display("Covered %0d sensor beats and %0d estimates over eight settings phases,",
                 beats_in, beats_out);
        $display("including zero and full-scale settings, word extremes and backpressure.");
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/kaf_pkg.sv
hdl/kaf_div.sv
hdl/kalman_angle_filter.sv
hdl/kalman_angle_filter_chk.sv
sim/tb_kalman_angle_filter.sv
